@@ rtl/hbbc_pkg.sv @@
// Shared types and constants of the HSV blob box and centroid block.
// No dependencies; imported by every other module of the block.
`default_nettype none

package hbbc_pkg;

    localparam int CNT_W      = 25;   // run and hit counters
    localparam int SUM_W      = 36;   // coordinate sums, also divider width
    localparam int FRAME_W    = 13;   // frame size registers and low corner
    localparam int CHAN_W     = 8;    // hue, saturation, value
    localparam int SIZE_W     = 13;   // signed blob size
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HUE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HUE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SAT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VAL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PIX     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HGT   = 3'd7;

    // register reset values
    localparam logic [CHAN_W-1:0]  RST_MIN_HUE     = 8'd170;
    localparam logic [CHAN_W-1:0]  RST_MAX_HUE     = 8'd10;
    localparam logic [CHAN_W-1:0]  RST_MIN_SAT     = 8'd100;
    localparam logic [CHAN_W-1:0]  RST_MIN_VAL     = 8'd100;
    localparam logic [FRAME_W-1:0] RST_MIN_RUN     = 13'd3;
    localparam logic [CNT_W-1:0]   RST_MIN_PIX     = 25'd50;
    localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH = 13'd640;
    localparam logic [FRAME_W-1:0] RST_FRAME_HGT   = 13'd480;

    // controller to datapath
    typedef struct packed {
        logic load_pix;   // non-final pixel accepted: update and emit its item
        logic frame_end;  // final pixel accepted: update, snapshot, restart, divide
        logic load_sum;   // quotients ready and output free: emit the summary item
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/hsv_blob_box_centroid.sv @@
// Top level of the HSV blob box and centroid block: stream packing and wiring.
// Depends on hbbc_pkg, hbbc_ctrl, hbbc_dp (and through it hbbc_div).
`default_nettype none

// Takes HSV pixels with their coordinates in raster order and gives one item per
// pixel: a flag telling whether the pixel was counted into the blob and, on the
// pixel marked with tlast, the frame summary (centroid, bounding box, size, hit
// count, detected flag), with m_axis_tlast marking that summary item. Pixels stream
// at one per clock while results are taken; a result waiting in the output register
// holds the input until it is taken, and a result taken in the same cycle frees the
// slot for the next pixel. After the last pixel of a frame the two centroid dividers
// run: they are restoring dividers that produce one quotient bit per cycle over 36
// steps, and input is held off until the summary has been loaded into the output
// register. Configuration is written through the plain write port; the user must
// write it only while the block is idle, as the block itself does not enforce this;
// frame width and height changes take effect at the next frame start.
module hsv_blob_box_centroid #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pos_x, pos_y, hue, saturation, brightness, zero fill
    input  wire logic [((2*COORD_BITS+24+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                              s_axis_tlast,     // frame_end
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // pixel_counted, centroid_x, centroid_y, box_min_x, box_max_x, box_min_y,
    // box_max_y, blob_size, hit_total, detected, zero fill
    output logic [((6*COORD_BITS+42+7)/8)*8-1:0]   m_axis_tdata,
    output logic                                   m_axis_tlast,     // frame_done
    input  wire logic                              i_cfg_we,
    input  wire logic [hbbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [hbbc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hbbc_pkg::*;

    localparam int OUT_RAW = 6*COORD_BITS + 42;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam int HUE_LO  = 2*COORD_BITS;

    t_cmd  cmd;
    t_stat stat;

    logic                  pixel_counted, frame_done, detected;
    logic [COORD_BITS-1:0] centroid_x, centroid_y, box_max_x, box_max_y;
    logic [COORD_BITS:0]   box_min_x, box_min_y;
    logic [SIZE_W-1:0]     blob_size;
    logic [CNT_W-1:0]      hit_total;

    hbbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hbbc_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pos_x         (s_axis_tdata[COORD_BITS-1:0]),
        .i_pos_y         (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_hue           (s_axis_tdata[HUE_LO+CHAN_W-1:HUE_LO]),
        .i_saturation    (s_axis_tdata[HUE_LO+2*CHAN_W-1:HUE_LO+CHAN_W]),
        .i_brightness    (s_axis_tdata[HUE_LO+3*CHAN_W-1:HUE_LO+2*CHAN_W]),
        .o_pixel_counted (pixel_counted),
        .o_frame_done    (frame_done),
        .o_centroid_x    (centroid_x),
        .o_centroid_y    (centroid_y),
        .o_box_min_x     (box_min_x),
        .o_box_max_x     (box_max_x),
        .o_box_min_y     (box_min_y),
        .o_box_max_y     (box_max_y),
        .o_blob_size     (blob_size),
        .o_hit_total     (hit_total),
        .o_detected      (detected)
    );

    assign m_axis_tdata = OUT_W'({detected, hit_total, blob_size, box_max_y, box_min_y,
                                  box_max_x, box_min_x, centroid_y, centroid_x,
                                  pixel_counted});
    assign m_axis_tlast = frame_done;

endmodule

`default_nettype wire

@@ rtl/hbbc_div.sv @@
// Restoring divider, one quotient bit per cycle, SUM_W steps per division.
// Depends on hbbc_pkg for the dividend and divisor widths.
`default_nettype none

module hbbc_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [hbbc_pkg::SUM_W-1:0] i_dividend,
    input  wire logic [hbbc_pkg::CNT_W-1:0] i_divisor,
    output logic                            o_busy,
    output logic [hbbc_pkg::SUM_W-1:0]      o_quotient
);
    import hbbc_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;

    logic [CNT_W:0] rem_sh;
    logic [CNT_W:0] diff;
    logic           ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[SUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        diff   = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_LAST;
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder stays below the divisor, so it fits CNT_W bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ rtl/hbbc_dp.sv @@
// Datapath: configuration registers, match and run logic, box and sum accumulators,
// frame snapshot, two centroid dividers and the output register. Uses hbbc_pkg, hbbc_div.
`default_nettype none

module hbbc_dp #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire hbbc_pkg::t_cmd                  i_cmd,
    output hbbc_pkg::t_stat                      o_stat,
    input  wire logic                            i_cfg_we,
    input  wire logic [hbbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [hbbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [COORD_BITS-1:0]           i_pos_x,
    input  wire logic [COORD_BITS-1:0]           i_pos_y,
    input  wire logic [hbbc_pkg::CHAN_W-1:0]     i_hue,
    input  wire logic [hbbc_pkg::CHAN_W-1:0]     i_saturation,
    input  wire logic [hbbc_pkg::CHAN_W-1:0]     i_brightness,
    output logic                                 o_pixel_counted,
    output logic                                 o_frame_done,
    output logic [COORD_BITS-1:0]                o_centroid_x,
    output logic [COORD_BITS-1:0]                o_centroid_y,
    output logic [COORD_BITS:0]                  o_box_min_x,
    output logic [COORD_BITS-1:0]                o_box_max_x,
    output logic [COORD_BITS:0]                  o_box_min_y,
    output logic [COORD_BITS-1:0]                o_box_max_y,
    output logic [hbbc_pkg::SIZE_W-1:0]          o_blob_size,
    output logic [hbbc_pkg::CNT_W-1:0]           o_hit_total,
    output logic                                 o_detected
);
    import hbbc_pkg::*;

    localparam int XW   = (COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W;
    localparam int SZ_W = XW + 3;

    // configuration
    logic [CHAN_W-1:0]  r_min_hue, r_max_hue, r_min_sat, r_min_val;
    logic [FRAME_W-1:0] r_min_run, r_frame_width, r_frame_hgt;
    logic [CNT_W-1:0]   r_min_pix;

    // frame accumulators
    logic [CNT_W-1:0]      r_run, n_run;
    logic [FRAME_W-1:0]    r_low_x, n_low_x, r_low_y, n_low_y;
    logic [COORD_BITS-1:0] r_high_x, n_high_x, r_high_y, n_high_y;
    logic [CNT_W-1:0]      r_hit, n_hit;
    logic [SUM_W-1:0]      r_sum_x, n_sum_x, r_sum_y, n_sum_y;

    // snapshot of the finished frame
    logic [FRAME_W-1:0]    r_snap_low_x, r_snap_low_y;
    logic [COORD_BITS-1:0] r_snap_high_x, r_snap_high_y;
    logic [CNT_W-1:0]      r_snap_hit;
    logic                  r_snap_pc, r_snap_det;

    // output register
    logic                  r_pc, r_done, r_det;
    logic [COORD_BITS-1:0] r_cx, r_cy, r_bmax_x, r_bmax_y;
    logic [COORD_BITS:0]   r_bmin_x, r_bmin_y;
    logic [SIZE_W-1:0]     r_size;
    logic [CNT_W-1:0]      r_hit_out;

    logic match, counted;
    logic [CNT_W-1:0] divisor;
    logic busy_x, busy_y;
    logic [SUM_W-1:0] quo_x, quo_y;

    logic signed [SZ_W-1:0] w_span, h_span, t_sum, t_half, t_inc, t_inc_half, sz;
    logic [XW:0] min_x_ext, min_y_ext;

    always_comb begin
        match   = (i_hue > r_min_hue || i_hue < r_max_hue)
                  && i_saturation > r_min_sat && i_brightness > r_min_val;
        counted = match && (r_run >= CNT_W'(r_min_run));

        n_run = match ? ((r_run != CNT_MAX) ? r_run + CNT_W'(1) : r_run) : '0;

        n_low_x  = r_low_x;
        n_high_x = r_high_x;
        n_low_y  = r_low_y;
        n_high_y = r_high_y;
        n_hit    = r_hit;
        n_sum_x  = r_sum_x;
        n_sum_y  = r_sum_y;
        if (counted) begin
            if (XW'(i_pos_x) < XW'(r_low_x)) n_low_x = FRAME_W'(i_pos_x);
            if (i_pos_x > r_high_x)          n_high_x = i_pos_x;
            if (XW'(i_pos_y) < XW'(r_low_y)) n_low_y = FRAME_W'(i_pos_y);
            if (i_pos_y > r_high_y)          n_high_y = i_pos_y;
            if (r_hit != CNT_MAX)            n_hit = r_hit + CNT_W'(1);
            n_sum_x = r_sum_x + SUM_W'(i_pos_x);
            n_sum_y = r_sum_y + SUM_W'(i_pos_y);
        end

        // an empty frame divides by one
        divisor = (n_hit == '0) ? CNT_W'(1) : n_hit;
    end

    // round half away from zero of (w + h) / 2
    always_comb begin
        w_span     = $signed(SZ_W'(r_snap_high_x)) - $signed(SZ_W'(r_snap_low_x));
        h_span     = $signed(SZ_W'(r_snap_high_y)) - $signed(SZ_W'(r_snap_low_y));
        t_sum      = w_span + h_span;
        t_half     = t_sum >>> 1;
        t_inc      = t_sum + $signed(SZ_W'(1));
        t_inc_half = t_inc >>> 1;
        sz         = t_sum[SZ_W-1] ? t_half : t_inc_half;
        min_x_ext  = (XW+1)'(r_snap_low_x);
        min_y_ext  = (XW+1)'(r_snap_low_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_hue     <= RST_MIN_HUE;
            r_max_hue     <= RST_MAX_HUE;
            r_min_sat     <= RST_MIN_SAT;
            r_min_val     <= RST_MIN_VAL;
            r_min_run     <= RST_MIN_RUN;
            r_min_pix     <= RST_MIN_PIX;
            r_frame_width <= RST_FRAME_WIDTH;
            r_frame_hgt   <= RST_FRAME_HGT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_HUE:     r_min_hue     <= i_cfg_data[CHAN_W-1:0];
                REG_MAX_HUE:     r_max_hue     <= i_cfg_data[CHAN_W-1:0];
                REG_MIN_SAT:     r_min_sat     <= i_cfg_data[CHAN_W-1:0];
                REG_MIN_VAL:     r_min_val     <= i_cfg_data[CHAN_W-1:0];
                REG_MIN_RUN:     r_min_run     <= i_cfg_data[FRAME_W-1:0];
                REG_MIN_PIX:     r_min_pix     <= i_cfg_data[CNT_W-1:0];
                REG_FRAME_WIDTH: r_frame_width <= i_cfg_data[FRAME_W-1:0];
                REG_FRAME_HGT:   r_frame_hgt   <= i_cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= '0;
            r_low_x  <= RST_FRAME_WIDTH;
            r_high_x <= '0;
            r_low_y  <= RST_FRAME_HGT;
            r_high_y <= '0;
            r_hit    <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
        end else if (i_cmd.frame_end) begin
            // restart with the frame size as it stands now
            r_run    <= '0;
            r_low_x  <= r_frame_width;
            r_high_x <= '0;
            r_low_y  <= r_frame_hgt;
            r_high_y <= '0;
            r_hit    <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
        end else if (i_cmd.load_pix) begin
            r_run    <= n_run;
            r_low_x  <= n_low_x;
            r_high_x <= n_high_x;
            r_low_y  <= n_low_y;
            r_high_y <= n_high_y;
            r_hit    <= n_hit;
            r_sum_x  <= n_sum_x;
            r_sum_y  <= n_sum_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_end) begin
            r_snap_low_x  <= n_low_x;
            r_snap_high_x <= n_high_x;
            r_snap_low_y  <= n_low_y;
            r_snap_high_y <= n_high_y;
            r_snap_hit    <= n_hit;
            r_snap_pc     <= counted;
            r_snap_det    <= n_hit > r_min_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_pc      <= counted;
            r_done    <= 1'b0;
            r_cx      <= '0;
            r_cy      <= '0;
            r_bmin_x  <= '0;
            r_bmax_x  <= '0;
            r_bmin_y  <= '0;
            r_bmax_y  <= '0;
            r_size    <= '0;
            r_hit_out <= '0;
            r_det     <= 1'b0;
        end else if (i_cmd.load_sum) begin
            r_pc      <= r_snap_pc;
            r_done    <= 1'b1;
            r_cx      <= quo_x[COORD_BITS-1:0];
            r_cy      <= quo_y[COORD_BITS-1:0];
            r_bmin_x  <= min_x_ext[COORD_BITS:0];
            r_bmax_x  <= r_snap_high_x;
            r_bmin_y  <= min_y_ext[COORD_BITS:0];
            r_bmax_y  <= r_snap_high_y;
            r_size    <= sz[SIZE_W-1:0];
            r_hit_out <= r_snap_hit;
            r_det     <= r_snap_det;
        end
    end

    hbbc_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.frame_end),
        .i_dividend (n_sum_x),
        .i_divisor  (divisor),
        .o_busy     (busy_x),
        .o_quotient (quo_x)
    );

    hbbc_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.frame_end),
        .i_dividend (n_sum_y),
        .i_divisor  (divisor),
        .o_busy     (busy_y),
        .o_quotient (quo_y)
    );

    assign o_stat.div_busy = busy_x | busy_y;

    assign o_pixel_counted = r_pc;
    assign o_frame_done    = r_done;
    assign o_centroid_x    = r_cx;
    assign o_centroid_y    = r_cy;
    assign o_box_min_x     = r_bmin_x;
    assign o_box_max_x     = r_bmax_x;
    assign o_box_min_y     = r_bmin_y;
    assign o_box_max_y     = r_bmax_y;
    assign o_blob_size     = r_size;
    assign o_hit_total     = r_hit_out;
    assign o_detected      = r_det;

endmodule

`default_nettype wire

@@ rtl/hbbc_ctrl.sv @@
// Controller: stream handshakes, output register valid and the wait for the dividers.
// Depends on hbbc_pkg for the command and status structs.
`default_nettype none

module hbbc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    input  wire logic            i_s_tlast,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    input  wire hbbc_pkg::t_stat i_stat,
    output hbbc_pkg::t_cmd       o_cmd
);
    import hbbc_pkg::*;

    typedef enum logic {
        S_PIX,
        S_DIV
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    logic slot_free, ready, accept;

    always_comb begin
        slot_free       = !r_out_valid || i_m_tready;
        ready           = (r_state == S_PIX) && slot_free;
        accept          = i_s_tvalid && ready;
        o_cmd.load_pix  = accept && !i_s_tlast;
        o_cmd.frame_end = accept && i_s_tlast;
        o_cmd.load_sum  = (r_state == S_DIV) && !i_stat.div_busy && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_PIX;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_PIX: begin
                    if (o_cmd.frame_end) r_state <= S_DIV;
                end
                S_DIV: begin
                    if (o_cmd.load_sum) r_state <= S_PIX;
                end
                default: r_state <= S_PIX;
            endcase
            // hold the item until taken
            if (o_cmd.load_pix || o_cmd.load_sum) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_tready = ready;
    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire
